>>> hdl/spi_pkg.sv
// Shared widths, constants and types for the segment pair intersection block.
`default_nettype none
package spi_pkg;
  localparam int CW  = 32;
  localparam int RF  = 24;
  localparam int PW  = 2 * (CW + 1);
  localparam int DW  = PW + 1;
  localparam int MW  = RF + 2;
  localparam int UW  = RF + 3;
  localparam int TW  = 62;
  localparam int IW  = 8;
  localparam int OFW = MW + CW + 1 - RF;
  localparam int SW  = OFW + 2;
  localparam int EPS_I = ((2 ** RF) + 5000) / 10000;

  localparam logic [IW-1:0] REG_DET_TOL = IW'(0);
  localparam logic [IW-1:0] REG_EDGES   = IW'(1);

  localparam logic signed [UW-1:0] RONE = UW'(2 ** RF);
  localparam logic signed [UW-1:0] REPS = UW'(EPS_I);

  typedef struct packed {
    logic signed [CW-1:0] a_sx, a_sy, a_sz, a_ex, a_ey, a_ez;
    logic signed [CW-1:0] b_sx, b_sy, b_sz, b_ex, b_ey, b_ez;
  } seg_pair_t;

  typedef struct packed {
    logic                 ident;
    logic                 par;
    logic signed [CW-1:0] sx0, sy0, sz0;
    logic signed [CW:0]   dx, dy, dz;
  } side_t;

  typedef struct packed {
    logic [DW:0]   rem;
    logic [DW-1:0] den;
    logic [RF:0]   q;
    logic          sat;
    logic          neg;
  } div_t;
endpackage
`default_nettype wire

>>> hdl/segment_pair_intersection_top.sv
// Top level of the segment pair intersection block.
// One segment pair enters per clock while in_ready is high and passes 32 register
// stages: the 4-stage cross-product front end, the 25-stage ratio divider and the
// 3-stage point multiply. A stall at out_ready freezes the whole pipeline,
// so in_ready follows out_ready whenever the output word is occupied.
`default_nettype none
module segment_pair_intersection_top import spi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [IW-1:0]        cfg_index,
  input  wire logic [TW-1:0]        cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [CW-1:0] in_a_start_x,
  input  wire logic signed [CW-1:0] in_a_start_y,
  input  wire logic signed [CW-1:0] in_a_start_z,
  input  wire logic signed [CW-1:0] in_a_end_x,
  input  wire logic signed [CW-1:0] in_a_end_y,
  input  wire logic signed [CW-1:0] in_a_end_z,
  input  wire logic signed [CW-1:0] in_b_start_x,
  input  wire logic signed [CW-1:0] in_b_start_y,
  input  wire logic signed [CW-1:0] in_b_start_z,
  input  wire logic signed [CW-1:0] in_b_end_x,
  input  wire logic signed [CW-1:0] in_b_end_y,
  input  wire logic signed [CW-1:0] in_b_end_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_intersects,
  output logic                      out_point_valid,
  output logic signed [CW-1:0]      out_cross_x,
  output logic signed [CW-1:0]      out_cross_y,
  output logic signed [CW-1:0]      out_cross_z
);
  logic [TW-1:0] tol_r;
  logic edges_r;
  logic en;
  seg_pair_t seg;
  logic f_valid, f_neg_a, f_neg_b;
  side_t f_side, d_side;
  logic [DW-1:0] f_mag_d, f_mag_a, f_mag_b;
  logic d_valid;
  logic signed [UW-1:0] d_ua, d_ub;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= '0;
      edges_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DET_TOL) begin
        tol_r <= cfg_data;
      end else if (cfg_index == REG_EDGES) begin
        edges_r <= cfg_data[0];
      end
    end
  end

  always_comb begin
    seg.a_sx = in_a_start_x;
    seg.a_sy = in_a_start_y;
    seg.a_sz = in_a_start_z;
    seg.a_ex = in_a_end_x;
    seg.a_ey = in_a_end_y;
    seg.a_ez = in_a_end_z;
    seg.b_sx = in_b_start_x;
    seg.b_sy = in_b_start_y;
    seg.b_sz = in_b_start_z;
    seg.b_ex = in_b_end_x;
    seg.b_ey = in_b_end_y;
    seg.b_ez = in_b_end_z;
  end

  spi_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .i_valid(in_valid), .i_seg(seg),
    .o_valid(f_valid), .o_side(f_side), .o_mag_d(f_mag_d), .o_mag_a(f_mag_a),
    .o_mag_b(f_mag_b), .o_neg_a(f_neg_a), .o_neg_b(f_neg_b)
  );

  spi_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .i_valid(f_valid), .i_side(f_side),
    .i_mag_d(f_mag_d), .i_mag_a(f_mag_a), .i_mag_b(f_mag_b),
    .i_neg_a(f_neg_a), .i_neg_b(f_neg_b), .i_tol(tol_r),
    .o_valid(d_valid), .o_side(d_side), .o_ua(d_ua), .o_ub(d_ub)
  );

  spi_point u_point (
    .clk(clk), .rst_n(rst_n), .en(en), .i_valid(d_valid), .i_side(d_side),
    .i_ua(d_ua), .i_ub(d_ub), .i_edges(edges_r),
    .o_valid(out_valid), .o_hit(out_intersects), .o_pvalid(out_point_valid),
    .o_x(out_cross_x), .o_y(out_cross_y), .o_z(out_cross_z)
  );
endmodule
`default_nettype wire

>>> hdl/spi_front.sv
// Differences, cross products, determinant and numerator magnitudes.
`default_nettype none
module spi_front import spi_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          i_valid,
  input  wire seg_pair_t     i_seg,
  output logic               o_valid,
  output side_t              o_side,
  output logic [DW-1:0]      o_mag_d,
  output logic [DW-1:0]      o_mag_a,
  output logic [DW-1:0]      o_mag_b,
  output logic               o_neg_a,
  output logic               o_neg_b
);
  logic [3:0] v_r;
  side_t s1_r, s2_r, s3_r, s4_r;
  logic signed [CW:0] bx_r, by_r, sx_r, sy_r;
  logic signed [PW-1:0] pd1_r, pd2_r, pa1_r, pa2_r, pb1_r, pb2_r;
  logic signed [DW-1:0] d_r, na_r, nb_r;
  logic [DW-1:0] md_r, ma_r, mb_r;
  logic nga_r, ngb_r;
  side_t s1_nxt;
  logic same, swap;

  always_comb begin
    same = i_seg.a_sx == i_seg.b_sx && i_seg.a_sy == i_seg.b_sy &&
           i_seg.a_sz == i_seg.b_sz && i_seg.a_ex == i_seg.b_ex &&
           i_seg.a_ey == i_seg.b_ey && i_seg.a_ez == i_seg.b_ez;
    swap = i_seg.a_sx == i_seg.b_ex && i_seg.a_sy == i_seg.b_ey &&
           i_seg.a_sz == i_seg.b_ez && i_seg.a_ex == i_seg.b_sx &&
           i_seg.a_ey == i_seg.b_sy && i_seg.a_ez == i_seg.b_sz;
    s1_nxt.ident = same || swap;
    s1_nxt.par   = 1'b0;
    s1_nxt.sx0   = i_seg.a_sx;
    s1_nxt.sy0   = i_seg.a_sy;
    s1_nxt.sz0   = i_seg.a_sz;
    s1_nxt.dx    = (CW+1)'(i_seg.a_ex) - (CW+1)'(i_seg.a_sx);
    s1_nxt.dy    = (CW+1)'(i_seg.a_ey) - (CW+1)'(i_seg.a_sy);
    s1_nxt.dz    = (CW+1)'(i_seg.a_ez) - (CW+1)'(i_seg.a_sz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      bx_r  <= (CW+1)'(i_seg.b_ex) - (CW+1)'(i_seg.b_sx);
      by_r  <= (CW+1)'(i_seg.b_ey) - (CW+1)'(i_seg.b_sy);
      sx_r  <= (CW+1)'(i_seg.a_sx) - (CW+1)'(i_seg.b_sx);
      sy_r  <= (CW+1)'(i_seg.a_sy) - (CW+1)'(i_seg.b_sy);
      s2_r  <= s1_r;
      pd1_r <= s1_r.dx * by_r;
      pd2_r <= s1_r.dy * bx_r;
      pa1_r <= bx_r * sy_r;
      pa2_r <= by_r * sx_r;
      pb1_r <= s1_r.dx * sy_r;
      pb2_r <= s1_r.dy * sx_r;
      s3_r  <= s2_r;
      d_r   <= DW'(pd1_r) - DW'(pd2_r);
      na_r  <= DW'(pa1_r) - DW'(pa2_r);
      nb_r  <= DW'(pb1_r) - DW'(pb2_r);
      s4_r  <= s3_r;
      md_r  <= d_r[DW-1]  ? (~d_r + 1'b1)  : d_r;
      ma_r  <= na_r[DW-1] ? (~na_r + 1'b1) : na_r;
      mb_r  <= nb_r[DW-1] ? (~nb_r + 1'b1) : nb_r;
      nga_r <= na_r[DW-1] ^ d_r[DW-1];
      ngb_r <= nb_r[DW-1] ^ d_r[DW-1];
    end
  end

  assign o_valid = v_r[3];
  assign o_side  = s4_r;
  assign o_mag_d = md_r;
  assign o_mag_a = ma_r;
  assign o_mag_b = mb_r;
  assign o_neg_a = nga_r;
  assign o_neg_b = ngb_r;
endmodule
`default_nettype wire

>>> hdl/spi_div.sv
// Pipelined restoring divider for both ratios, one quotient bit per stage.
`default_nettype none
module spi_div import spi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               i_valid,
  input  wire side_t              i_side,
  input  wire logic [DW-1:0]      i_mag_d,
  input  wire logic [DW-1:0]      i_mag_a,
  input  wire logic [DW-1:0]      i_mag_b,
  input  wire logic               i_neg_a,
  input  wire logic               i_neg_b,
  input  wire logic [TW-1:0]      i_tol,
  output logic                    o_valid,
  output side_t                   o_side,
  output logic signed [UW-1:0]    o_ua,
  output logic signed [UW-1:0]    o_ub
);
  logic [RF:0] v_r;
  div_t la_r [0:RF];
  div_t lb_r [0:RF];
  side_t sd_r [0:RF];
  side_t s0_nxt;
  logic [MW-1:0] mag_a, mag_b;

  function automatic div_t div_pre(input logic [DW-1:0] num, input logic [DW-1:0] den,
                                   input logic neg);
    div_t r;
    r.den = den;
    r.neg = neg;
    r.sat = {1'b0, num} >= {den, 1'b0};
    r.q   = '0;
    r.rem = {1'b0, num};
    if (!r.sat && num >= den) begin
      r.q   = (RF+1)'(1);
      r.rem = {1'b0, num - den};
    end
    return r;
  endfunction

  function automatic div_t div_step(input div_t s);
    div_t r;
    logic [DW:0] t;
    r = s;
    t = {s.rem[DW-1:0], 1'b0};
    r.q = {s.q[RF-1:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      r.rem  = t - {1'b0, s.den};
      r.q[0] = 1'b1;
    end else begin
      r.rem = t;
    end
    return r;
  endfunction

  always_comb begin
    s0_nxt     = i_side;
    s0_nxt.par = DW'(i_tol) >= i_mag_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RF-1:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r[0] <= div_pre(i_mag_a, i_mag_d, i_neg_a);
      lb_r[0] <= div_pre(i_mag_b, i_mag_d, i_neg_b);
      sd_r[0] <= s0_nxt;
      for (int k = 1; k <= RF; k++) begin
        la_r[k] <= div_step(la_r[k-1]);
        lb_r[k] <= div_step(lb_r[k-1]);
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  always_comb begin
    mag_a = la_r[RF].sat ? (MW'(1) << (RF + 1)) : MW'(la_r[RF].q);
    mag_b = lb_r[RF].sat ? (MW'(1) << (RF + 1)) : MW'(lb_r[RF].q);
    o_ua  = la_r[RF].neg ? -signed'(UW'(mag_a)) : signed'(UW'(mag_a));
    o_ub  = lb_r[RF].neg ? -signed'(UW'(mag_b)) : signed'(UW'(mag_b));
  end

  assign o_valid = v_r[RF];
  assign o_side  = sd_r[RF];
endmodule
`default_nettype wire

>>> hdl/spi_point.sv
// Hit and range flags, point along the first segment, saturation.
`default_nettype none
module spi_point import spi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               i_valid,
  input  wire side_t              i_side,
  input  wire logic signed [UW-1:0] i_ua,
  input  wire logic signed [UW-1:0] i_ub,
  input  wire logic               i_edges,
  output logic                    o_valid,
  output logic                    o_hit,
  output logic                    o_pvalid,
  output logic signed [CW-1:0]    o_x,
  output logic signed [CW-1:0]    o_y,
  output logic signed [CW-1:0]    o_z
);
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (CW - 1));

  logic [2:0] v_r;
  logic hit1_r, pv1_r, hit2_r, pv2_r, hit3_r, pv3_r;
  logic [MW-1:0] mua_r;
  logic [CW:0] mag1_r [0:2];
  logic neg1_r [0:2];
  logic neg2_r [0:2];
  logic signed [CW-1:0] st1_r [0:2];
  logic signed [CW-1:0] st2_r [0:2];
  logic [MW+CW:0] prod_r [0:2];
  logic signed [CW-1:0] pt_r [0:2];
  logic signed [CW:0] dif [0:2];
  logic signed [CW-1:0] st [0:2];
  logic signed [SW-1:0] sum [0:2];
  logic signed [CW-1:0] pt_nxt [0:2];
  logic near_any, band, hit_nxt, pv_nxt;

  function automatic logic near(input logic signed [UW-1:0] v, input logic signed [UW-1:0] c);
    return (v >= c - REPS) && (v <= c + REPS);
  endfunction

  always_comb begin
    dif[0] = i_side.dx;
    dif[1] = i_side.dy;
    dif[2] = i_side.dz;
    st[0]  = i_side.sx0;
    st[1]  = i_side.sy0;
    st[2]  = i_side.sz0;
    near_any = near(i_ua, '0) || near(i_ua, RONE) || near(i_ub, '0) || near(i_ub, RONE);
    band = (i_ua > -REPS) && (i_ua < RONE + REPS) && (i_ub > -REPS) && (i_ub < RONE + REPS);
    hit_nxt = i_side.ident ||
              (!i_side.par && !(!i_edges && near_any) && band);
    pv_nxt  = !i_side.par && (i_ua >= 0) && (i_ua <= RONE) && (i_ub >= 0) && (i_ub <= RONE);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = neg2_r[i] ? SW'(st2_r[i]) - signed'(SW'(prod_r[i][MW+CW:RF]))
                         : SW'(st2_r[i]) + signed'(SW'(prod_r[i][MW+CW:RF]));
      if (!pv2_r) begin
        pt_nxt[i] = '0;
      end else if (sum[i] > SAT_HI) begin
        pt_nxt[i] = SAT_HI[CW-1:0];
      end else if (sum[i] < SAT_LO) begin
        pt_nxt[i] = SAT_LO[CW-1:0];
      end else begin
        pt_nxt[i] = sum[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit1_r <= hit_nxt;
      pv1_r  <= pv_nxt;
      mua_r  <= i_ua[MW-1:0];
      hit2_r <= hit1_r;
      pv2_r  <= pv1_r;
      hit3_r <= hit2_r;
      pv3_r  <= pv2_r;
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= dif[i][CW] ? (~dif[i] + 1'b1) : dif[i];
        neg1_r[i] <= dif[i][CW];
        st1_r[i]  <= st[i];
        prod_r[i] <= mua_r * mag1_r[i];
        neg2_r[i] <= neg1_r[i];
        st2_r[i]  <= st1_r[i];
        pt_r[i]   <= pt_nxt[i];
      end
    end
  end

  assign o_valid  = v_r[2];
  assign o_hit    = hit3_r;
  assign o_pvalid = pv3_r;
  assign o_x      = pt_r[0];
  assign o_y      = pt_r[1];
  assign o_z      = pt_r[2];
endmodule
`default_nettype wire

>>> test/tb_segment_pair_intersection_top.sv
// Self-checking testbench for the segment pair intersection block.
`timescale 1ns / 1ps
module tb_segment_pair_intersection_top;
  import spi_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    bit                   hit;
    bit                   valid;
    logic signed [CW-1:0] x, y, z;
  } cross_t;

  typedef struct {
    seg_pair_t pair;
    bit        known;
    cross_t    res;
  } dir_row_t;

  localparam logic [IW-1:0] REG_SPARE = IW'(2);
  localparam logic [IW-1:0] REG_LAST  = IW'(255);
  localparam int  WATCH_LIMIT = 5000;
  localparam int  DRAIN_CYC   = 40;
  localparam int  HOLD_CYC    = 400;
  localparam longint ONE_Q    = longint'(1) << RF;
  localparam logic signed [CW-1:0] Q1 = 32'sh0001_0000;
  localparam logic signed [CW-1:0] Q2 = 32'sh0002_0000;
  localparam logic signed [CW-1:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] MINC = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [TW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_a_start_x = '0, in_a_start_y = '0, in_a_start_z = '0;
  logic signed [CW-1:0] in_a_end_x = '0, in_a_end_y = '0, in_a_end_z = '0;
  logic signed [CW-1:0] in_b_start_x = '0, in_b_start_y = '0, in_b_start_z = '0;
  logic signed [CW-1:0] in_b_end_x = '0, in_b_end_y = '0, in_b_end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_intersects, out_point_valid;
  logic signed [CW-1:0] out_cross_x, out_cross_y, out_cross_z;

  logic [TW-1:0] tol_reg = '0;
  bit edges_on = 1'b1;
  cross_t pending_q[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cyc = 0;

  segment_pair_intersection_top dut (.*);

  always #1 clk = ~clk;

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint div_ratio(wide_t num, wide_t den);
    wide_t n, d;
    longint q;
    n = wabs(num);
    d = wabs(den);
    if (n >= (d <<< 1)) q = longint'(1) << (RF + 1);
    else q = longint'((n <<< RF) / d);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [CW-1:0] walk_along(longint start, longint diff,
                                                      longint ua);
    longint off, s;
    off = ((ua < 0 ? -ua : ua) * (diff < 0 ? -diff : diff)) >>> RF;
    s = (diff < 0) ? start - off : start + off;
    if (s > longint'(MAXC)) s = longint'(MAXC);
    if (s < longint'(MINC)) s = longint'(MINC);
    return s[CW-1:0];
  endfunction

  function automatic bit close_to(longint v, longint c);
    return (v - c <= longint'(EPS_I)) && (v - c >= -longint'(EPS_I));
  endfunction

  function automatic cross_t predict_cross(seg_pair_t p);
    longint ax, ay, bx, by, sx, sy, ua, ub;
    wide_t dd, na, nb;
    bit ident;
    cross_t r;
    ident = (p.a_sx == p.b_sx && p.a_sy == p.b_sy && p.a_sz == p.b_sz &&
             p.a_ex == p.b_ex && p.a_ey == p.b_ey && p.a_ez == p.b_ez) ||
            (p.a_sx == p.b_ex && p.a_sy == p.b_ey && p.a_sz == p.b_ez &&
             p.a_ex == p.b_sx && p.a_ey == p.b_sy && p.a_ez == p.b_sz);
    ax = longint'(p.a_ex) - longint'(p.a_sx);
    ay = longint'(p.a_ey) - longint'(p.a_sy);
    bx = longint'(p.b_ex) - longint'(p.b_sx);
    by = longint'(p.b_ey) - longint'(p.b_sy);
    sx = longint'(p.a_sx) - longint'(p.b_sx);
    sy = longint'(p.a_sy) - longint'(p.b_sy);
    dd = wide_t'(ax) * wide_t'(by) - wide_t'(ay) * wide_t'(bx);
    na = wide_t'(bx) * wide_t'(sy) - wide_t'(by) * wide_t'(sx);
    nb = wide_t'(ax) * wide_t'(sy) - wide_t'(ay) * wide_t'(sx);
    r = '{hit: 1'b0, valid: 1'b0, x: '0, y: '0, z: '0};
    if (wabs(dd) > wide_t'(tol_reg)) begin
      ua = div_ratio(na, dd);
      ub = div_ratio(nb, dd);
      if (!edges_on && (close_to(ua, 0) || close_to(ua, ONE_Q) ||
                        close_to(ub, 0) || close_to(ub, ONE_Q)))
        r.hit = 1'b0;
      else
        r.hit = ua > -EPS_I && ua < ONE_Q + EPS_I && ub > -EPS_I && ub < ONE_Q + EPS_I;
      r.valid = ua >= 0 && ua <= ONE_Q && ub >= 0 && ub <= ONE_Q;
      if (r.valid) begin
        r.x = walk_along(longint'(p.a_sx), ax, ua);
        r.y = walk_along(longint'(p.a_sy), ay, ua);
        r.z = walk_along(longint'(p.a_sz), longint'(p.a_ez) - longint'(p.a_sz), ua);
      end
    end
    if (ident) r.hit = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cyc <= 0;
    else if (quiet_cyc + 1 >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      quiet_cyc <= quiet_cyc + 1;
  end

  always @(posedge clk) begin
    cross_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("extra result word", 0, 1);
      end else begin
        w = pending_q.pop_front();
        if (out_intersects !== w.hit) report_mismatch("intersects", w.hit, out_intersects);
        if (out_point_valid !== w.valid)
          report_mismatch("point_valid", w.valid, out_point_valid);
        if (out_cross_x !== w.x) report_mismatch("cross_x", w.x, out_cross_x);
        if (out_cross_y !== w.y) report_mismatch("cross_y", w.y, out_cross_y);
        if (out_cross_z !== w.z) report_mismatch("cross_z", w.z, out_cross_z);
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYC;
      out_ready <= 1'b0;
    end else
      out_ready <= $urandom_range(99) >= rx_idle_pct;
  end

  task automatic send_pair(seg_pair_t p, bit known, cross_t res);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_a_start_x <= p.a_sx; in_a_start_y <= p.a_sy; in_a_start_z <= p.a_sz;
    in_a_end_x <= p.a_ex;   in_a_end_y <= p.a_ey;   in_a_end_z <= p.a_ez;
    in_b_start_x <= p.b_sx; in_b_start_y <= p.b_sy; in_b_start_z <= p.b_sz;
    in_b_end_x <= p.b_ex;   in_b_end_y <= p.b_ey;   in_b_end_z <= p.b_ez;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(known ? res : predict_cross(p));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [TW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DET_TOL) tol_reg = val;
    else if (idx == REG_EDGES) edges_on = val[0];
  endtask

  function automatic logic signed [CW-1:0] near_coord();
    return CW'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(99);
    if (kind < 80) begin
      p.a_sx = near_coord(); p.a_sy = near_coord();
      p.a_ex = near_coord(); p.a_ey = near_coord();
      p.b_sx = near_coord(); p.b_sy = near_coord();
      p.b_ex = near_coord(); p.b_ey = near_coord();
    end
    if (kind < 15) begin
      if (kind[0]) {p.b_sx, p.b_sy, p.b_sz, p.b_ex, p.b_ey, p.b_ez} =
          {p.a_sx, p.a_sy, p.a_sz, p.a_ex, p.a_ey, p.a_ez};
      else {p.b_sx, p.b_sy, p.b_sz, p.b_ex, p.b_ey, p.b_ez} =
          {p.a_ex, p.a_ey, p.a_ez, p.a_sx, p.a_sy, p.a_sz};
    end else if (kind < 27) begin
      p.b_sx = p.a_ex; p.b_sy = p.a_ey;
    end else if (kind < 37) begin
      p.b_sx = p.a_sx + near_coord(); p.b_sy = p.a_sy + near_coord();
      p.b_ex = p.b_sx + p.a_ex - p.a_sx; p.b_ey = p.b_sy + p.a_ey - p.a_sy;
    end else if (kind < 47) begin
      p.b_sx = p.a_sx + CW'($urandom_range(0, 6)) - 3;
      p.b_sy = p.a_sy + CW'($urandom_range(0, 6)) - 3;
    end
    return p;
  endfunction

  task automatic random_run(int count, bit pause_once);
    for (int i = 0; i < count; i++) begin
      if (pause_once && i == count / 2) begin
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      send_pair(random_pair(), 1'b0, '{default: '0});
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{'{default: '0}, 1'b1, '{1'b1, 1'b0, '0, '0, '0}},
    '{'{default: MAXC}, 1'b1, '{1'b1, 1'b0, '0, '0, '0}},
    '{'{default: MINC}, 1'b1, '{1'b1, 1'b0, '0, '0, '0}},
    '{'{MINC, MAXC, 0, MAXC, MINC, Q1, MAXC, MINC, Q1, MINC, MAXC, 0}, 1'b1,
      '{1'b1, 1'b0, '0, '0, '0}},
    '{'{0, 0, 0, Q2, Q2, Q2, 0, Q2, 0, Q2, 0, 0}, 1'b1,
      '{1'b1, 1'b1, Q1, Q1, Q1}},
    '{'{0, 0, 0, Q2, 0, 0, 0, Q1, 0, Q2, Q1, 0}, 1'b1,
      '{1'b0, 1'b0, '0, '0, '0}},
    '{'{0, 0, 0, Q2, Q2, 0, Q2, Q2, 0, Q2, 0, 0}, 1'b0, '{default: '0}},
    '{'{0, 0, 0, Q2, Q2, 0, 0, 0, 0, Q2, 0, 0}, 1'b0, '{default: '0}},
    '{'{0, 0, 0, Q2, 0, 0, Q1, 0, 0, 3 * Q1, 0, 0}, 1'b0, '{default: '0}},
    '{'{0, 0, 0, Q1, Q1, 0, 0, Q2, 0, Q2, 0, 0}, 1'b0, '{default: '0}},
    '{'{0, 0, 0, Q2, 0, 0, Q1, 3, 0, Q1, Q1, 0}, 1'b0, '{default: '0}},
    '{'{0, 0, 0, Q2, 0, 0, Q1, -3, 0, Q1, Q1, 0}, 1'b0, '{default: '0}},
    '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, 0, MAXC, MINC, 0},
      1'b0, '{default: '0}},
    '{'{MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MINC, 0, MINC, MAXC, 0},
      1'b0, '{default: '0}},
    '{'{0, 0, MAXC, Q2, Q2, MINC, 0, Q2, 0, Q2, 0, 0}, 1'b0, '{default: '0}},
    '{'{0, 0, 0, Q2, Q2, 0, 0, Q2, 5, Q2, 0, 7}, 1'b0, '{default: '0}}
  };

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 20;
    rx_idle_pct = 67;
    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].known, dir_rows[i].res);
    random_run(220, 1'b1);
    drain();

    write_reg(REG_EDGES, TW'(0));
    write_reg(REG_SPARE, {TW{1'b1}});
    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].known, dir_rows[i].res);
    tx_idle_pct = 67;
    rx_idle_pct = 20;
    random_run(200, 1'b0);
    drain();

    write_reg(REG_DET_TOL, {TW{1'b1}});
    write_reg(REG_EDGES, TW'(1));
    random_run(60, 1'b0);
    drain();

    write_reg(REG_DET_TOL, TW'({$urandom, $urandom}) >> $urandom_range(10, 40));
    write_reg(REG_LAST, TW'(0));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    random_run(220, 1'b0);
    drain();

    write_reg(REG_DET_TOL, TW'(0));
    write_reg(REG_EDGES, TW'(0));
    random_run(200, 1'b1);
    drain();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
